/* rtl/motor_command_receiver_watchdog_assert.svh */
// assertion macros shared by the checker of the motor command receiver
// no dependencies; included by files that hold concurrent assertions
`ifndef MOTOR_COMMAND_RECEIVER_WATCHDOG_ASSERT_SVH
`define MOTOR_COMMAND_RECEIVER_WATCHDOG_ASSERT_SVH

// same-cycle implication, off while in reset
`define MCRW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcrw assertion failed");

// next-cycle implication, off while in reset
`define MCRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcrw assertion failed");

`endif

/* rtl/mcrw_pkg.sv */
// types and constants of the motor command receiver with link watchdog
// no dependencies; used by the interfaces and all modules
`default_nettype none
package mcrw_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned TIMEOUT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

	localparam logic REQ_PACKET = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	localparam logic [BYTE_W-1:0] OP_DRIVE = 8'h01;
	localparam logic [BYTE_W-1:0] OP_STOP  = 8'h02;
	localparam logic [BYTE_W-1:0] OP_BRAKE = 8'h03;
	localparam logic [BYTE_W-1:0] OP_PING  = 8'h04;

	localparam logic [BYTE_W-1:0] DUTY_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] DUTY_FULL = 8'hFF;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_OK    = 2'd1,
		ST_BADCK = 2'd2,
		ST_WDOG  = 2'd3
	} link_status_t;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] cmd_byte;
		logic [BYTE_W-1:0] left_byte;
		logic [BYTE_W-1:0] right_byte;
		logic [BYTE_W-1:0] check_byte;
	} req_item_t;

	// input stage towards execute stage
	typedef struct packed {
		logic      valid;
		req_item_t item;
	} stage_t;

endpackage
`default_nettype wire

/* rtl/mcrw_req_if.sv */
// request channel: command packet or millisecond tick
// depends on mcrw_pkg
`default_nettype none
interface mcrw_req_if;
	import mcrw_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [BYTE_W-1:0] cmd_byte;
	logic [BYTE_W-1:0] left_byte;
	logic [BYTE_W-1:0] right_byte;
	logic [BYTE_W-1:0] check_byte;

	modport source (output valid, output req_type, output cmd_byte, output left_byte,
		output right_byte, output check_byte, input ready);
	modport sink (input valid, input req_type, input cmd_byte, input left_byte,
		input right_byte, input check_byte, output ready);
endinterface
`default_nettype wire

/* rtl/mcrw_rsp_if.sv */
// result channel: motor duties and link status
// depends on mcrw_pkg
`default_nettype none
interface mcrw_rsp_if;
	import mcrw_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] left_duty;
	logic [BYTE_W-1:0] right_duty;
	logic [1:0]        link_status;

	modport source (output valid, output left_duty, output right_duty,
		output link_status, input ready);
	modport sink (input valid, input left_duty, input right_duty,
		input link_status, output ready);
endinterface
`default_nettype wire

/* rtl/mcrw_cfg_if.sv */
// configuration write channel for the watchdog timeout
// depends on mcrw_pkg
`default_nettype none
interface mcrw_cfg_if;
	import mcrw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TIMEOUT_W-1:0] timeout_ms;

	modport source (output valid, output timeout_ms, input ready);
	modport sink (input valid, input timeout_ms, output ready);
endinterface
`default_nettype wire

/* rtl/mcrw_in_reg.sv */
// input register stage of the motor command receiver
// depends on mcrw_pkg and mcrw_req_if
`default_nettype none
module mcrw_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	mcrw_req_if.sink           req,
	input  wire logic          take,
	output mcrw_pkg::stage_t   stage
);
	import mcrw_pkg::*;

	logic      valid_s1;
	req_item_t item_s1;

	// refill in the same cycle the held item moves on
	assign req.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{req_type:   req.req_type,
			             cmd_byte:   req.cmd_byte,
			             left_byte:  req.left_byte,
			             right_byte: req.right_byte,
			             check_byte: req.check_byte};
		end
	end

	assign stage = '{valid: valid_s1, item: item_s1};
endmodule
`default_nettype wire

/* rtl/mcrw_exec.sv */
// execute stage: packet check, command decode, watchdog and result register
// depends on mcrw_pkg, mcrw_rsp_if and mcrw_cfg_if
`default_nettype none
module mcrw_exec #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mcrw_pkg::stage_t stage,
	output logic               take,
	mcrw_rsp_if.source         rsp,
	mcrw_cfg_if.sink           cfg
);
	import mcrw_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [BYTE_W-1:0]      left_q, right_q;
	logic [COUNT_WIDTH-1:0] count_q;
	link_status_t           status_q;
	logic                   out_valid_q;

	logic [BYTE_W-1:0]      left_n, right_n;
	logic [COUNT_WIDTH-1:0] count_n;
	link_status_t           status_n;
	req_item_t              it;

	assign it   = stage.item;
	assign take = stage.valid && (!out_valid_q || rsp.ready);

	assign cfg.ready = 1'b1;

	always_comb begin
		left_n   = left_q;
		right_n  = right_q;
		count_n  = count_q;
		status_n = status_q;
		if (it.req_type == REQ_PACKET) begin
			if ((it.cmd_byte ^ it.left_byte ^ it.right_byte) != it.check_byte) begin
				status_n = ST_BADCK;
			end else begin
				status_n = ST_OK;
				unique case (it.cmd_byte)
					OP_DRIVE: begin
						left_n  = it.left_byte;
						right_n = it.right_byte;
					end
					OP_STOP: begin
						left_n  = DUTY_ZERO;
						right_n = DUTY_ZERO;
					end
					OP_BRAKE: begin
						left_n  = DUTY_FULL;
						right_n = DUTY_FULL;
					end
					OP_PING: begin
						count_n = '0;
					end
					default: begin
					end
				endcase
			end
		end else if (count_q != '1) begin
			// saturating millisecond count
			count_n = count_q + COUNT_WIDTH'(1);
		end
		if (CMP_W'(count_n) > CMP_W'(timeout_q)) begin
			left_n   = DUTY_ZERO;
			right_n  = DUTY_ZERO;
			status_n = ST_WDOG;
		end
	end

	// the state registers double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			left_q      <= DUTY_ZERO;
			right_q     <= DUTY_ZERO;
			count_q     <= '0;
			status_q    <= ST_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				timeout_q <= cfg.timeout_ms;
			end
			if (take) begin
				left_q      <= left_n;
				right_q     <= right_n;
				count_q     <= count_n;
				status_q    <= status_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.left_duty   = left_q;
	assign rsp.right_duty  = right_q;
	assign rsp.link_status = status_q;
endmodule
`default_nettype wire

/* rtl/motor_command_receiver_watchdog.sv */
// top level of the motor command receiver with link watchdog
// depends on mcrw_pkg, the three channel interfaces, mcrw_in_reg and mcrw_exec
//
//  channel | dir | payload                                           | handshake
//  req     | in  | req_type, cmd_byte, left_byte, right_byte, check  | valid/ready
//  rsp     | out | left_duty, right_duty, link_status                | valid/ready
//  cfg     | in  | timeout_ms                                        | valid/ready
//
// one item per cycle sustained while rsp is ready; a taken item reaches rsp through the
// input register, then the duty/status register that also holds the state
// arst_n clears duties, counter and status and sets the timeout to 500 ms
// a stalled result holds the execute stage; one further item waits in the input register
// cfg is always ready and takes effect from the next executed item
`default_nettype none
module motor_command_receiver_watchdog #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mcrw_req_if.sink   req,
	mcrw_rsp_if.source rsp,
	mcrw_cfg_if.sink   cfg
);
	import mcrw_pkg::*;

	stage_t stage;
	logic   take;

	mcrw_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.stage  (stage)
	);

	mcrw_exec #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage),
		.take   (take),
		.rsp    (rsp),
		.cfg    (cfg)
	);
endmodule
`default_nettype wire

/* rtl/mcrw_checker.sv */
// port-level checker for the motor command receiver, bound to the top level
// depends on motor_command_receiver_watchdog_assert.svh and mcrw_pkg
`default_nettype none
`include "motor_command_receiver_watchdog_assert.svh"
module mcrw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] left_duty,
	input wire logic [7:0] right_duty,
	input wire logic [1:0] link_status
);
	import mcrw_pkg::*;

	logic        stalled;
	logic        wdog;
	logic        duties_off;
	logic [17:0] rsp_word;

	assign stalled    = rsp_valid && !rsp_ready;
	assign wdog       = link_status == ST_WDOG;
	assign duties_off = (left_duty == DUTY_ZERO) && (right_duty == DUTY_ZERO);
	assign rsp_word   = {left_duty, right_duty, link_status};

	`MCRW_ASSERT_NEXT(a_stall_valid, clk, arst_n, stalled, rsp_valid)
	`MCRW_ASSERT_NEXT(a_stall_hold, clk, arst_n, stalled, $stable(rsp_word))
	`MCRW_ASSERT_NOW(a_known, clk, arst_n, rsp_valid, !$isunknown(rsp_word))
	// watchdog forces both motors off
	`MCRW_ASSERT_NOW(a_wdog_off, clk, arst_n, rsp_valid && wdog, duties_off)
endmodule

bind motor_command_receiver_watchdog mcrw_checker u_mcrw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.left_duty   (rsp.left_duty),
	.right_duty  (rsp.right_duty),
	.link_status (rsp.link_status)
);
`default_nettype wire
